// ===== design/spi_master_shift_engine_assert.svh =====
// Assertion macros for the SPI shift engine.
`ifndef SPI_MASTER_SHIFT_ENGINE_ASSERT_SVH
`define SPI_MASTER_SHIFT_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SPI_SE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("spi shift engine: same-cycle check failed");

// Next-cycle implication.
`define SPI_SE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("spi shift engine: next-cycle check failed");

`else

`define SPI_SE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SPI_SE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== design/spi_se_pkg.sv =====
package spi_se_pkg;

  localparam int MaxWordBits = 16;
  localparam int WordW       = MaxWordBits;
  localparam int CntW        = $clog2(MaxWordBits + 1);
  localparam int IdxW        = $clog2(MaxWordBits);
  localparam int ByteLen     = (8 < MaxWordBits) ? 8 : MaxWordBits;
  localparam int HalfLen     = (16 < MaxWordBits) ? 16 : MaxWordBits;
  localparam int QDepth      = 2;
  localparam int QPtrW       = 1;
  localparam int QCntW       = 2;

  localparam logic [1:0] CMD_START8  = 2'd1;
  localparam logic [1:0] CMD_START16 = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_START8,
    OP_START16
  } op_e;

  typedef enum logic [1:0] {
    REG_BIT_ORDER,
    REG_CPOL,
    REG_CPHA,
    REG_HALF_TICKS
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] tx_data;
    logic        miso;
  } spi_in_t;

  typedef struct packed {
    logic        sck;
    logic        mosi;
    logic        busy_res;
    logic        done_res;
    logic [15:0] rx_data;
  } spi_out_t;

  // Classified request held in the queue between front and engine.
  typedef struct packed {
    op_e         op;
    logic [15:0] tx_data;
    logic        miso;
  } spi_req_t;

  typedef struct packed {
    logic msb_first;
    logic cpol;
    logic cpha;
    logic [7:0] half_ticks;
  } spi_cfg_t;

  // Position in the word of the bit under transfer.
  function automatic logic [IdxW-1:0] bit_idx(logic [CntW-1:0] n, logic [CntW-1:0] w,
                                             logic msb_first);
    logic [CntW-1:0] v;
    if (n == '0 || n > w) begin
      v = '0;
    end else if (msb_first) begin
      v = n - CntW'(1);
    end else begin
      v = w - n;
    end
    return v[IdxW-1:0];
  endfunction

endpackage

// ===== design/spi_se_front.sv =====
module spi_se_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  spi_se_pkg::spi_in_t  in_req_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output spi_se_pkg::spi_req_t q_req_o
);

  spi_se_pkg::spi_req_t                 mem_q [spi_se_pkg::QDepth];
  logic [spi_se_pkg::QPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [spi_se_pkg::QPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [spi_se_pkg::QCntW-1:0]         cnt_q, cnt_d;
  spi_se_pkg::spi_req_t                 cls;
  logic                                 push, pop;

  always_comb begin
    cls.tx_data = in_req_i.tx_data;
    cls.miso    = in_req_i.miso;
    case (in_req_i.cmd)
      spi_se_pkg::CMD_START8:  cls.op = spi_se_pkg::OP_START8;
      spi_se_pkg::CMD_START16: cls.op = spi_se_pkg::OP_START16;
      default:                 cls.op = spi_se_pkg::OP_TICK;
    endcase
  end

  assign in_stall_o = (cnt_q == spi_se_pkg::QCntW'(spi_se_pkg::QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_req_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + spi_se_pkg::QCntW'(push) - spi_se_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== design/spi_se_core.sv =====
module spi_se_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  spi_se_pkg::spi_req_t q_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output spi_se_pkg::spi_out_t out_res_o
);

  spi_se_pkg::spi_cfg_t            cfg_q;
  logic [spi_se_pkg::WordW-1:0]    tx_q, tx_d;
  logic [spi_se_pkg::WordW-1:0]    rx_q, rx_d;
  logic [spi_se_pkg::CntW-1:0]     bits_q, bits_d;
  logic [spi_se_pkg::CntW-1:0]     wbits_q, wbits_d;
  logic                            phase_q, phase_d;
  logic [7:0]                      tick_q, tick_d;
  logic                            sck_q, sck_d;
  logic                            mosi_q, mosi_d;
  logic                            active_q, active_d;
  logic                            out_valid_q, out_valid_d;
  spi_se_pkg::spi_out_t            out_q, out_d;
  logic                            pop;
  logic                            half_end;
  logic [spi_se_pkg::IdxW-1:0]     idx_cur;

  assign pop     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.msb_first  <= 1'b1;
      cfg_q.cpol       <= 1'b0;
      cfg_q.cpha       <= 1'b0;
      cfg_q.half_ticks <= 8'd1;
    end else if (cfg_we_i) begin
      case (spi_se_pkg::cfg_reg_e'(cfg_idx_i))
        spi_se_pkg::REG_BIT_ORDER:  cfg_q.msb_first  <= cfg_data_i[0];
        spi_se_pkg::REG_CPOL:       cfg_q.cpol       <= cfg_data_i[0];
        spi_se_pkg::REG_CPHA:       cfg_q.cpha       <= cfg_data_i[0];
        spi_se_pkg::REG_HALF_TICKS: cfg_q.half_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero half period ends after one tick, same as one.
  assign half_end = ({1'b0, tick_q} + 9'd1) >= {1'b0, cfg_q.half_ticks};
  assign idx_cur  = spi_se_pkg::bit_idx(bits_q, wbits_q, cfg_q.msb_first);

  always_comb begin
    tx_d        = tx_q;
    rx_d        = rx_q;
    bits_d      = bits_q;
    wbits_d     = wbits_q;
    phase_d     = phase_q;
    tick_d      = tick_q;
    sck_d       = sck_q;
    mosi_d      = mosi_q;
    active_d    = active_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop) begin
      out_d.done_res = 1'b0;
      out_d.rx_data  = '0;
      if (active_q) begin
        if (half_end) begin
          tick_d = '0;
          if (!phase_q) begin
            // opening of half B: second sck edge, sample miso
            phase_d       = 1'b1;
            sck_d         = ~(cfg_q.cpol ^ cfg_q.cpha);
            rx_d[idx_cur] = rx_q[idx_cur] | q_req_i.miso;
          end else begin
            bits_d  = bits_q - spi_se_pkg::CntW'(1);
            phase_d = 1'b0;
            if (bits_d == '0) begin
              active_d       = 1'b0;
              sck_d          = cfg_q.cpol;
              out_d.done_res = 1'b1;
              out_d.rx_data  = 16'(rx_q);
            end else begin
              mosi_d = tx_q[spi_se_pkg::bit_idx(bits_d, wbits_q, cfg_q.msb_first)];
              sck_d  = cfg_q.cpol ^ cfg_q.cpha;
            end
          end
        end else begin
          tick_d = tick_q + 8'd1;
        end
      end else begin
        sck_d = cfg_q.cpol;
        if (q_req_i.op == spi_se_pkg::OP_START8 || q_req_i.op == spi_se_pkg::OP_START16) begin
          if (q_req_i.op == spi_se_pkg::OP_START8) begin
            wbits_d = spi_se_pkg::CntW'(spi_se_pkg::ByteLen);
            tx_d    = spi_se_pkg::WordW'(q_req_i.tx_data[7:0]);
          end else begin
            wbits_d = spi_se_pkg::CntW'(spi_se_pkg::HalfLen);
            tx_d    = spi_se_pkg::WordW'(q_req_i.tx_data);
          end
          bits_d   = wbits_d;
          rx_d     = '0;
          phase_d  = 1'b0;
          tick_d   = '0;
          active_d = 1'b1;
          mosi_d   = tx_d[spi_se_pkg::bit_idx(bits_d, wbits_d, cfg_q.msb_first)];
          sck_d    = cfg_q.cpol ^ cfg_q.cpha;
        end
      end
      out_d.sck      = sck_d;
      out_d.mosi     = mosi_d;
      out_d.busy_res = active_d;
      out_valid_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q        <= '0;
      rx_q        <= '0;
      bits_q      <= '0;
      wbits_q     <= spi_se_pkg::CntW'(spi_se_pkg::ByteLen);
      phase_q     <= 1'b0;
      tick_q      <= '0;
      sck_q       <= 1'b0;
      mosi_q      <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tx_q        <= tx_d;
      rx_q        <= rx_d;
      bits_q      <= bits_d;
      wbits_q     <= wbits_d;
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      sck_q       <= sck_d;
      mosi_q      <= mosi_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ===== design/spi_master_shift_engine.sv =====
// Channel   | handshake              | payload
// ----------+------------------------+---------------------------------
// in        | in_valid_i / in_stall_o   | in_req_i  (cmd, tx_data, miso)
// out       | out_valid_o / out_stall_i | out_res_o (sck, mosi, busy, done, rx)
// cfg       | cfg_we_i, cfg_idx_i       | cfg_data_i
//
// One request per cycle while in_stall_o is low; each yields exactly one result,
// held in a queue slot, then in the output register. The rate is set by the
// engine update in spi_se_core. in_stall_o rises only when the two-entry
// queue is full, which happens only while out_stall_i holds the output register.
// Reset is asynchronous, active low; configuration resets to MSB first, mode 0,
// one tick per half period.
`include "spi_master_shift_engine_assert.svh"

module spi_master_shift_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  spi_se_pkg::spi_in_t  in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output spi_se_pkg::spi_out_t out_res_o
);

  logic                 q_valid;
  logic                 q_pop;
  spi_se_pkg::spi_req_t q_req;

  spi_se_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_req_o    (q_req)
  );

  spi_se_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_req_i     (q_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  `SPI_SE_ASSERT_IMP(a_done_not_busy, clk_i, rst_ni, out_valid_o && out_res_o.done_res, !out_res_o.busy_res)
  `SPI_SE_ASSERT_IMP(a_rx_zero_idle, clk_i, rst_ni, out_valid_o && !out_res_o.done_res, out_res_o.rx_data == 16'd0)
  `SPI_SE_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, in_valid_i && !in_stall_o, q_valid)
  `SPI_SE_ASSERT_NEXT(a_pop_shows, clk_i, rst_ni, q_pop, out_valid_o)

endmodule

// ===== test/tb.sv =====
module tb;
  import spi_se_pkg::*;

  localparam logic [1:0] CmdSpare   = 2'd3;
  localparam int         HoldCycles = 64;

  // Expected serial line states, one per request, in order of acceptance.
  class spi_line_tracker;
    bit          msb_first  = 1'b1;
    bit          cpol       = 1'b0;
    bit          cpha       = 1'b0;
    logic [7:0]  half_ticks = 8'd1;
    logic [15:0] tx_word    = '0;
    logic [15:0] rx_word    = '0;
    logic [4:0]  bits_rem   = '0;
    logic [4:0]  word_len   = 5'd8;
    logic [7:0]  tick_cnt   = '0;
    bit          in_half_b  = 1'b0;
    bit          sck_lvl    = 1'b0;
    bit          mosi_lvl   = 1'b0;
    bit          busy       = 1'b0;
    spi_out_t    expected_lines[$];
    int          errors     = 0;

    function void set_reg(cfg_reg_e r, logic [7:0] d);
      case (r)
        REG_BIT_ORDER:  msb_first = d[0];
        REG_CPOL: begin
          cpol = d[0];
          if (!busy) sck_lvl = cpol;
        end
        REG_CPHA:       cpha = d[0];
        REG_HALF_TICKS: half_ticks = d;
        default: ;
      endcase
    endfunction

    function int cur_bit();
      int n, w, idx;
      n = bits_rem;
      w = word_len;
      if (n == 0 || n > w) return 0;
      idx = msb_first ? n - 1 : w - n;
      return (idx >= MaxWordBits) ? 0 : idx;
    endfunction

    function void open_half_a();
      mosi_lvl = tx_word[cur_bit()];
      sck_lvl  = cpol ^ cpha;
    endfunction

    function void note_request(spi_in_t r);
      spi_out_t e;
      e = '0;
      if (busy) begin
        // zero half period counts as one tick
        if (int'(tick_cnt) + 1 >= int'(half_ticks)) begin
          tick_cnt = '0;
          if (!in_half_b) begin
            in_half_b = 1'b1;
            sck_lvl   = ~(cpol ^ cpha);
            if (r.miso) rx_word[cur_bit()] = 1'b1;
          end else begin
            bits_rem  = bits_rem - 5'd1;
            in_half_b = 1'b0;
            if (bits_rem == '0) begin
              busy       = 1'b0;
              sck_lvl    = cpol;
              e.done_res = 1'b1;
              e.rx_data  = rx_word;
            end else begin
              open_half_a();
            end
          end
        end else begin
          tick_cnt = tick_cnt + 8'd1;
        end
      end else begin
        sck_lvl = cpol;
        if (r.cmd == OP_START8 || r.cmd == OP_START16) begin
          word_len  = (r.cmd == OP_START8) ? 5'(ByteLen) : 5'(HalfLen);
          tx_word   = (r.cmd == OP_START8) ? {8'h00, r.tx_data[7:0]} : r.tx_data;
          rx_word   = '0;
          bits_rem  = word_len;
          in_half_b = 1'b0;
          tick_cnt  = '0;
          busy      = 1'b1;
          open_half_a();
        end
      end
      e.sck      = sck_lvl;
      e.mosi     = mosi_lvl;
      e.busy_res = busy;
      expected_lines.push_back(e);
    endfunction

    function void cmp(string field, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0h, got %0h", field, want, seen);
        errors++;
      end
    endfunction

    function void check_result(spi_out_t got);
      spi_out_t e;
      if (expected_lines.size() == 0) begin
        $error("result %h with no request outstanding", got);
        errors++;
        return;
      end
      e = expected_lines.pop_front();
      cmp("sck", 16'(e.sck), 16'(got.sck));
      cmp("mosi", 16'(e.mosi), 16'(got.mosi));
      cmp("busy_res", 16'(e.busy_res), 16'(got.busy_res));
      cmp("done_res", 16'(e.done_res), 16'(got.done_res));
      cmp("rx_data", e.rx_data, got.rx_data);
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  spi_in_t    in_req_i;
  logic       out_valid_o;
  logic       out_stall_i;
  spi_out_t   out_res_o;

  logic       hold_req;
  bit         hold_done = 1'b0;
  int         n_accepted = 0;

  spi_line_tracker book = new;

  spi_master_shift_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls more first, then sender idles more, then neither
  function automatic int gap_pct();
    if (n_accepted < 480) return 31;
    if (n_accepted < 960) return 50;
    return 0;
  endfunction

  function automatic int stall_pct();
    if (n_accepted < 480) return 50;
    if (n_accepted < 960) return 31;
    return 0;
  endfunction

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        // long hold-off so the queue fills and the input stalls
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct());
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) book.check_result(out_res_o);
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_req(spi_in_t r);
    while ($urandom_range(99) < gap_pct()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    book.note_request(r);
    n_accepted <= n_accepted + 1;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [7:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= d;
    @(posedge clk_i);
    book.set_reg(r, d);
  endtask

  // upper data bits are junk for the single-bit registers
  task automatic load_config(bit msb, bit pol, bit pha, logic [7:0] half);
    write_reg(REG_BIT_ORDER, {7'($urandom_range(127)), msb});
    write_reg(REG_CPOL, {7'($urandom_range(127)), pol});
    write_reg(REG_CPHA, {7'($urandom_range(127)), pha});
    write_reg(REG_HALF_TICKS, half);
    cfg_we_i <= 1'b0;
  endtask

  function automatic spi_in_t next_random_req();
    spi_in_t r;
    int      pick;
    pick = $urandom_range(99);
    if (pick < 8)       r.cmd = OP_START8;
    else if (pick < 16) r.cmd = OP_START16;
    else if (pick < 19) r.cmd = CmdSpare;
    else                r.cmd = OP_TICK;
    pick = $urandom_range(9);
    if (pick == 0)      r.tx_data = 16'h0000;
    else if (pick == 1) r.tx_data = 16'hFFFF;
    else                r.tx_data = 16'($urandom);
    r.miso = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic run_phase(bit msb, bit pol, bit pha, logic [7:0] half, int count,
                           int hold_at);
    load_config(msb, pol, pha, half);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req <= 1'b1;
      send_req(next_random_req());
    end
    settle();
  endtask

  function automatic spi_in_t mk_req(logic [1:0] c, logic [15:0] d, logic m);
    spi_in_t r;
    r.cmd     = c;
    r.tx_data = d;
    r.miso    = m;
    return r;
  endfunction

  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_BIT_ORDER;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    hold_req   <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: MSB first, mode 0, one tick per half
    send_req(mk_req(OP_TICK, 16'h0000, 1'b0));
    send_req(mk_req(CmdSpare, 16'hFFFF, 1'b1));
    send_req(mk_req(OP_START8, 16'hFFA5, 1'b1));
    for (int i = 1; i <= 15; i++) begin
      // a start in the middle of the transfer must be ignored
      send_req(mk_req((i == 3) ? OP_START16 : OP_TICK, 16'($urandom), 1'(i)));
    end
    // start on the finishing tick, then a real 16-bit start
    send_req(mk_req(OP_START16, 16'h1234, 1'b0));
    send_req(mk_req(OP_START16, 16'h8001, 1'b1));
    repeat (4) send_req(mk_req(OP_TICK, 16'h0000, 1'b1));
    settle();

    run_phase(1'b0, 1'b1, 1'b0, 8'd2, 200, -1);
    run_phase(1'b1, 1'b0, 1'b1, 8'd0, 150, -1);
    run_phase(1'b0, 1'b1, 1'b1, 8'd3, 150, -1);
    run_phase(1'b1, 1'b1, 1'b1, 8'd255, 250, -1);
    // follows the slow phase, so the write lands mid-transfer
    run_phase(1'b0, 1'b0, 1'b0, 8'd1, 200, 50);
    repeat (4) begin
      run_phase(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                8'($urandom_range(1, 4)), 120, -1);
    end
    repeat (6) @(posedge clk_i);

    if (book.errors == 0 && book.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
